// File: rtl/core/lwbc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lwbc_pkg
// Shared types and constants of the bucket cache controller: opcodes,
// register indexes, growth arithmetic constants and the sequencer states.
// ============================================================================
package lwbc_pkg;

    localparam int unsigned RATE_W     = 12;
    localparam int unsigned FRAC_BITS  = 8;
    localparam int unsigned BUCKET_INC = 2;

    localparam logic [RATE_W-1:0] RATE_RESET       = 12'd512;
    localparam int unsigned       INIT_COUNT_RESET = 1024;

    localparam logic [1:0] OP_READ          = 2'd0;
    localparam logic [1:0] OP_FULL_WRITE    = 2'd1;
    localparam logic [1:0] OP_PARTIAL_WRITE = 2'd2;
    localparam logic [1:0] OP_INVALID       = 2'd3;

    localparam logic REG_GROWTH_RATE = 1'b0;
    localparam logic REG_INIT_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN,
        ST_COMMIT
    } lwbc_state_t;

endpackage

// File: rtl/core/lwbc_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// lwbc_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module lwbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/lru_writeback_bucket_cache.sv
`timescale 1ns / 1ps
// ============================================================================
// lru_writeback_bucket_cache
// Tag and LRU policy controller for a small fully associative write-back
// cache of buckets, with bucket count growth.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+-------------------------------------
//   request  | in_valid / in_stall  | opcode, bucket
//   response | out_valid / out_stall| status, hit, slot, need_fetch,
//            |                      | need_writeback, victim_bucket, grew,
//            |                      | new_bucket_count
//   config   | cfg_we               | cfg_index, cfg_wdata
//
// After its request transfer, a request passes through the growth product
// (ST_MUL), a scan of every slot through the single tag/stamp compare unit
// reading the slot RAM (ST_SCAN), and the commit (ST_COMMIT) that loads the
// response register. The next request is taken in ST_IDLE after the commit.
// An invalid opcode goes from its transfer straight to the commit.
// The response sits in an output register; a new request is taken while it
// waits, and the commit holds only if the previous response is still stalled.
// Reset clears all slots at once through the valid bits; no clearing pass.
// ============================================================================
module lru_writeback_bucket_cache
    import lwbc_pkg::*;
#(
    parameter int SLOTS       = 8,
    parameter int BUCKET_BITS = 24,
    parameter int STAMP_BITS  = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic                                  cfg_index,
    input  logic [((BUCKET_BITS+1 > RATE_W) ? BUCKET_BITS+1 : RATE_W)-1:0] cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            opcode,
    input  logic [BUCKET_BITS-1:0]                bucket,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  status,
    output logic                                  hit,
    output logic [$clog2(SLOTS)-1:0]              slot,
    output logic                                  need_fetch,
    output logic                                  need_writeback,
    output logic [BUCKET_BITS-1:0]                victim_bucket,
    output logic                                  grew,
    output logic [BUCKET_BITS:0]                  new_bucket_count
);

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int COUNT_W = BUCKET_BITS + 1;
    localparam int PROD_W  = RATE_W + COUNT_W;
    localparam int CAND_W  = PROD_W - FRAC_BITS;
    localparam int ENTRY_W = BUCKET_BITS + 1 + STAMP_BITS;

    localparam logic [COUNT_W-1:0]    COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};
    localparam logic [SLOT_W-1:0]     LAST_IDX  = SLOT_W'(SLOTS - 1);

    lwbc_state_t state_reg, state_next;

    logic [RATE_W-1:0]      rate_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic [STAMP_BITS-1:0]  use_cnt_reg;
    logic [SLOTS-1:0]       valid_reg;

    logic [1:0]             op_reg;
    logic [BUCKET_BITS-1:0] bkt_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SLOT_W-1:0]      idx_reg;

    logic                   found_reg;
    logic [SLOT_W-1:0]      hit_idx_reg;
    logic                   hit_dirty_reg;
    logic [STAMP_BITS-1:0]  min_stamp_reg;
    logic [SLOT_W-1:0]      min_idx_reg;
    logic                   min_valid_reg;
    logic                   min_dirty_reg;
    logic [BUCKET_BITS-1:0] min_tag_reg;

    logic                   out_valid_reg;
    logic                   status_reg;
    logic                   hit_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic                   fetch_reg;
    logic                   wb_reg;
    logic [BUCKET_BITS-1:0] victim_reg;
    logic                   grew_reg;
    logic [COUNT_W-1:0]     new_count_reg;

    logic                   accept;
    logic                   out_free;
    logic                   commit_go;
    logic                   scan_active;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic [ENTRY_W-1:0]     ram_wdata;

    logic [BUCKET_BITS-1:0] rd_tag;
    logic                   rd_dirty;
    logic [STAMP_BITS-1:0]  rd_stamp;
    logic                   rd_valid;
    logic [STAMP_BITS-1:0]  eff_stamp;
    logic                   rd_match;

    logic                   is_write;
    logic [SLOT_W-1:0]      sel;
    logic                   sel_dirty;
    logic [COUNT_W-1:0]     bkt_plus;
    logic [PROD_W-1:0]      lhs;
    logic [CAND_W-1:0]      cand;
    logic [COUNT_W-1:0]     cand_sat;
    logic                   do_grow;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (opcode == OP_INVALID) ? ST_COMMIT : ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        scan_active = 1'b0;
        commit_go   = 1'b0;
        ram_raddr   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_MUL:
            begin
                ram_raddr = '0;
            end
            ST_SCAN:
            begin
                scan_active = 1'b1;
                ram_raddr   = idx_reg + SLOT_W'(1);
            end
            ST_COMMIT:
            begin
                commit_go = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Slot RAM: tag, dirty, stamp
    // ------------------------------------------------------------------------
    assign is_write  = (op_reg != OP_READ);
    assign sel       = found_reg ? hit_idx_reg : min_idx_reg;
    assign sel_dirty = is_write || (found_reg && hit_dirty_reg);
    assign ram_wdata = {bkt_reg, sel_dirty, use_cnt_reg};

    lwbc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (commit_go && (op_reg != OP_INVALID)),
        .waddr (sel),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Shared compare unit: one slot per cycle
    // ------------------------------------------------------------------------
    assign rd_tag    = ram_rdata[ENTRY_W-1 -: BUCKET_BITS];
    assign rd_dirty  = ram_rdata[STAMP_BITS];
    assign rd_stamp  = ram_rdata[STAMP_BITS-1:0];
    assign rd_valid  = valid_reg[idx_reg];
    assign eff_stamp = rd_valid ? rd_stamp : '0;
    assign rd_match  = rd_valid && (rd_tag == bkt_reg);

    // ------------------------------------------------------------------------
    // Growth and commit arithmetic
    // ------------------------------------------------------------------------
    assign bkt_plus = {1'b0, bkt_reg} + COUNT_W'(BUCKET_INC);
    assign lhs      = (op_reg == OP_READ)
                    ? {{(PROD_W-COUNT_W-FRAC_BITS){1'b0}}, 1'b0, bkt_reg, {FRAC_BITS{1'b0}}}
                    : {{(PROD_W-COUNT_W-FRAC_BITS){1'b0}}, bkt_plus, {FRAC_BITS{1'b0}}};
    assign cand     = (lhs > prod_reg) ? CAND_W'(bkt_plus) : prod_reg[PROD_W-1:FRAC_BITS];
    assign cand_sat = (cand > CAND_W'(COUNT_MAX)) ? COUNT_MAX : cand[COUNT_W-1:0];
    assign do_grow  = ({1'b0, bkt_reg} >= count_reg) && (cand_sat > count_reg);

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= RATE_RESET;
            count_reg     <= COUNT_W'(INIT_COUNT_RESET);
            use_cnt_reg   <= '0;
            valid_reg     <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GROWTH_RATE: rate_reg  <= cfg_wdata[RATE_W-1:0];
                    REG_INIT_COUNT:  count_reg <= cfg_wdata[COUNT_W-1:0];
                    default:         rate_reg  <= rate_reg;
                endcase
            end

            // advance the use counter, saturating
            if (accept && (opcode != OP_INVALID) && (use_cnt_reg != STAMP_MAX))
            begin
                use_cnt_reg <= use_cnt_reg + STAMP_BITS'(1);
            end

            if (state_reg == ST_MUL)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (scan_active)
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
                if (rd_match)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (commit_go && (op_reg != OP_INVALID))
            begin
                valid_reg[sel] <= 1'b1;
                if (do_grow)
                begin
                    count_reg <= cand_sat;
                end
            end

            if (commit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            bkt_reg <= bucket;
        end

        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(rate_reg) * PROD_W'(count_reg);
        end

        if (scan_active)
        begin
            if (rd_match && !found_reg)
            begin
                hit_idx_reg   <= idx_reg;
                hit_dirty_reg <= rd_dirty;
            end
            // keep the lowest index on equal stamps
            if ((idx_reg == '0) || (eff_stamp < min_stamp_reg))
            begin
                min_stamp_reg <= eff_stamp;
                min_idx_reg   <= idx_reg;
                min_valid_reg <= rd_valid;
                min_dirty_reg <= rd_dirty;
                min_tag_reg   <= rd_tag;
            end
        end

        if (commit_go)
        begin
            if (op_reg == OP_INVALID)
            begin
                status_reg    <= 1'b1;
                hit_reg       <= 1'b0;
                slot_reg      <= '0;
                fetch_reg     <= 1'b0;
                wb_reg        <= 1'b0;
                victim_reg    <= '0;
                grew_reg      <= 1'b0;
                new_count_reg <= count_reg;
            end
            else
            begin
                status_reg    <= 1'b0;
                hit_reg       <= found_reg;
                slot_reg      <= sel;
                fetch_reg     <= !found_reg && (op_reg != OP_FULL_WRITE);
                wb_reg        <= !found_reg && min_valid_reg && min_dirty_reg;
                victim_reg    <= (!found_reg && min_valid_reg) ? min_tag_reg : '0;
                grew_reg      <= do_grow;
                new_count_reg <= do_grow ? cand_sat : count_reg;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign hit              = hit_reg;
    assign slot             = slot_reg;
    assign need_fetch       = fetch_reg;
    assign need_writeback   = wb_reg;
    assign victim_bucket    = victim_reg;
    assign grew             = grew_reg;
    assign new_bucket_count = new_count_reg;

endmodule
